/* rtl/core/lcd_pkg.sv */
package lcd_pkg;

    localparam int FRAC_BITS = 8;

    // Formula selection codes held in the mode register.
    typedef enum logic [1:0] {
        MODE_CIE76   = 2'd0,
        MODE_GRAPHIC = 2'd1,
        MODE_TEXTILE = 2'd2
    } t_mode;

    // CIE94 weights K1 and K2 with 16 fraction bits.
    localparam logic [11:0] K1_GRAPHIC = 12'd2949;
    localparam logic [11:0] K2_GRAPHIC = 12'd983;
    localparam logic [11:0] K1_TEXTILE = 12'd3146;
    localparam logic [11:0] K2_TEXTILE = 12'd918;
    localparam logic [28:0] ROUND_HALF = 29'd32768;
    localparam logic [12:0] SCALE_ONE  = 13'(1 << FRAC_BITS);

    localparam logic [16:0] DIFF_MAX = 17'd131071;

    // Square root unit: 36-bit radicand, 18-bit root, one root bit per stage.
    localparam int SQRT_IN_W   = 36;
    localparam int SQRT_OUT_W  = 18;
    localparam int SQRT_STAGES = SQRT_OUT_W;

    // Divider: quotient below 2**17, divisor below 2**13, one quotient bit per stage.
    localparam int DIV_Q_W    = 17;
    localparam int DIV_NUM_W  = DIV_Q_W + FRAC_BITS;
    localparam int DIV_DEN_W  = 13;
    localparam int DIV_REM_W  = DIV_DEN_W + 1;
    localparam int DIV_STAGES = DIV_Q_W;

    typedef struct packed {
        logic [SQRT_IN_W-1:0]  rad;
        logic [SQRT_OUT_W+1:0] rem;
        logic [SQRT_OUT_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [DIV_REM_W-1:0] rem;
        logic [DIV_Q_W-1:0]   num_lo;
        logic [DIV_Q_W-1:0]   quo;
        logic [DIV_DEN_W-1:0] den;
    } t_div;

    // Side data that rides along the chroma square roots.
    typedef struct packed {
        logic        valid;
        logic [32:0] ab2;
        logic [33:0] sum76;
        logic [29:0] dl2;
    } t_side_a;

    // Side data that rides along the hue square root.
    typedef struct packed {
        logic                 valid;
        logic                 flag;
        logic [29:0]          tl;
        logic [33:0]          sum76;
        logic [15:0]          dc;
        logic [DIV_DEN_W-1:0] sc;
        logic [DIV_DEN_W-1:0] sh;
    } t_side_b;

    // Side data that rides along the dividers.
    typedef struct packed {
        logic        valid;
        logic        flag;
        logic [29:0] tl;
        logic [33:0] sum76;
    } t_side_c;

    // Side data that rides along the final square root.
    typedef struct packed {
        logic valid;
        logic flag;
    } t_side_d;

    // Magnitude of a 17-bit two's-complement value; it always fits 16 bits here.
    function automatic logic [15:0] mag17(input logic [16:0] v);
        logic [16:0] neg;
        neg = 17'd0 - v;
        return v[16] ? neg[15:0] : v[15:0];
    endfunction

    // One restoring square root step, producing one root bit.
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt                 o;
        logic [SQRT_OUT_W+3:0] trial;
        logic [SQRT_OUT_W+3:0] test;
        trial = {s.rem, s.rad[SQRT_IN_W-1 -: 2]};
        test  = (SQRT_OUT_W+4)'({s.root, 2'b01});
        o.rad = {s.rad[SQRT_IN_W-3:0], 2'b00};
        if (trial >= test) begin
            o.rem  = (SQRT_OUT_W+2)'(trial - test);
            o.root = {s.root[SQRT_OUT_W-2:0], 1'b1};
        end else begin
            o.rem  = trial[SQRT_OUT_W+1:0];
            o.root = {s.root[SQRT_OUT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // Set up a division whose quotient is known to stay below 2**DIV_Q_W.
    function automatic t_div div_init(input logic [DIV_NUM_W-1:0] num,
                                      input logic [DIV_DEN_W-1:0] den);
        t_div o;
        o.rem    = DIV_REM_W'(num[DIV_NUM_W-1:DIV_Q_W]);
        o.num_lo = num[DIV_Q_W-1:0];
        o.quo    = '0;
        o.den    = den;
        return o;
    endfunction

    // One restoring division step, producing one quotient bit.
    function automatic t_div div_step(input t_div s);
        t_div                 o;
        logic [DIV_REM_W-1:0] trial;
        trial    = {s.rem[DIV_REM_W-2:0], s.num_lo[DIV_Q_W-1]};
        o.num_lo = {s.num_lo[DIV_Q_W-2:0], 1'b0};
        o.den    = s.den;
        if (trial >= DIV_REM_W'(s.den)) begin
            o.rem = trial - DIV_REM_W'(s.den);
            o.quo = {s.quo[DIV_Q_W-2:0], 1'b1};
        end else begin
            o.rem = trial;
            o.quo = {s.quo[DIV_Q_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

/* rtl/core/lcd_sqrt.sv */
// Pipelined floor square root, one root bit per stage, advancing while i_en is high.
module lcd_sqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [lcd_pkg::SQRT_IN_W-1:0]   i_radicand,
    output logic [lcd_pkg::SQRT_OUT_W-1:0]  o_root
);

    lcd_pkg::t_sqrt w_stage [0:lcd_pkg::SQRT_STAGES-1];
    lcd_pkg::t_sqrt r_stage [1:lcd_pkg::SQRT_STAGES];

    always_comb begin
        w_stage[0].rad  = i_radicand;
        w_stage[0].rem  = '0;
        w_stage[0].root = '0;
        for (int k = 1; k < lcd_pkg::SQRT_STAGES; k++) begin
            w_stage[k] = r_stage[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < lcd_pkg::SQRT_STAGES; k++) begin
                r_stage[k+1] <= lcd_pkg::sqrt_step(w_stage[k]);
            end
        end
    end

    assign o_root = r_stage[lcd_pkg::SQRT_STAGES].root;

endmodule

/* rtl/core/lab_color_difference_top.sv */
// Color difference of two CIELAB colors in fixed point with 8 fraction bits. The mode
// register selects CIE76 (plain Euclidean distance), CIE94 graphic arts or CIE94
// textiles; the unused mode code behaves as CIE76. One color pair can enter in every
// clock cycle while the output is not stalled, and each produces exactly one result.
// The pipeline holds three square roots in series (the two chroma roots run side by
// side, one root bit per stage, 18 stages each), the two dividers for the chroma and
// hue quotients running side by side (one quotient bit per stage, 17 stages), and
// nine further register stages. A stall on the output, while it is valid, freezes
// the whole pipeline and is passed straight back to the input stall. The mode register
// must be written only while no transaction is in flight. The hue_clamped output is set
// when rounding made the squared hue difference negative and it was clamped to zero; it
// is always clear in CIE76 mode. Results above the 17-bit output range saturate.
module lab_color_difference_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [14:0]        i_light_first,
    input  logic signed [15:0] i_green_red_first,
    input  logic signed [15:0] i_blue_yellow_first,
    input  logic [14:0]        i_light_second,
    input  logic signed [15:0] i_green_red_second,
    input  logic signed [15:0] i_blue_yellow_second,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [16:0]        o_difference,
    output logic               o_hue_clamped
);

    // Mode register.
    logic [1:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lcd_pkg::MODE_CIE76;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    logic w_is94;
    logic w_graphic;
    logic w_textile;
    assign w_graphic = (r_mode == lcd_pkg::MODE_GRAPHIC);
    assign w_textile = (r_mode == lcd_pkg::MODE_TEXTILE);
    assign w_is94    = w_graphic || w_textile;

    // The whole pipeline moves unless a finished result sits stalled at the output.
    logic w_adv;
    assign w_adv      = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    // Stage A: differences and magnitudes.
    logic        r_a_vld;
    logic [14:0] r_a_dl;
    logic [15:0] r_a_da, r_a_db, r_a_ua1, r_a_ub1, r_a_ua2, r_a_ub2;
    logic [15:0] w_dl_s, w_dl_n;

    assign w_dl_s = {1'b0, i_light_first} - {1'b0, i_light_second};
    assign w_dl_n = 16'd0 - w_dl_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_in_valid;
            r_a_dl  <= w_dl_s[15] ? w_dl_n[14:0] : w_dl_s[14:0];
            r_a_da  <= lcd_pkg::mag17({i_green_red_first[15], i_green_red_first}
                                      - {i_green_red_second[15], i_green_red_second});
            r_a_db  <= lcd_pkg::mag17({i_blue_yellow_first[15], i_blue_yellow_first}
                                      - {i_blue_yellow_second[15], i_blue_yellow_second});
            r_a_ua1 <= lcd_pkg::mag17({i_green_red_first[15], i_green_red_first});
            r_a_ub1 <= lcd_pkg::mag17({i_blue_yellow_first[15], i_blue_yellow_first});
            r_a_ua2 <= lcd_pkg::mag17({i_green_red_second[15], i_green_red_second});
            r_a_ub2 <= lcd_pkg::mag17({i_blue_yellow_second[15], i_blue_yellow_second});
        end
    end

    // Stage B: squares.
    logic        r_b_vld;
    logic [29:0] r_b_dl2;
    logic [31:0] r_b_da2, r_b_db2, r_b_ua1, r_b_ub1, r_b_ua2, r_b_ub2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv) begin
            r_b_vld <= r_a_vld;
            r_b_dl2 <= 30'(r_a_dl) * 30'(r_a_dl);
            r_b_da2 <= 32'(r_a_da) * 32'(r_a_da);
            r_b_db2 <= 32'(r_a_db) * 32'(r_a_db);
            r_b_ua1 <= 32'(r_a_ua1) * 32'(r_a_ua1);
            r_b_ub1 <= 32'(r_a_ub1) * 32'(r_a_ub1);
            r_b_ua2 <= 32'(r_a_ua2) * 32'(r_a_ua2);
            r_b_ub2 <= 32'(r_a_ub2) * 32'(r_a_ub2);
        end
    end

    // Stage C: sums of squares.
    logic [32:0]      r_c_rad1, r_c_rad2;
    lcd_pkg::t_side_a r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side.valid <= 1'b0;
        end else if (w_adv) begin
            r_c_side.valid <= r_b_vld;
            r_c_rad1       <= 33'(r_b_ua1) + 33'(r_b_ub1);
            r_c_rad2       <= 33'(r_b_ua2) + 33'(r_b_ub2);
            r_c_side.ab2   <= 33'(r_b_da2) + 33'(r_b_db2);
            r_c_side.sum76 <= 34'(r_b_dl2) + 34'(r_b_da2) + 34'(r_b_db2);
            r_c_side.dl2   <= r_b_dl2;
        end
    end

    // Chroma of both colors.
    logic [lcd_pkg::SQRT_OUT_W-1:0] w_c1_root, w_c2_root;

    lcd_sqrt u_sqrt_c1 (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_radicand (lcd_pkg::SQRT_IN_W'(r_c_rad1)),
        .o_root     (w_c1_root)
    );

    lcd_sqrt u_sqrt_c2 (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_radicand (lcd_pkg::SQRT_IN_W'(r_c_rad2)),
        .o_root     (w_c2_root)
    );

    lcd_pkg::t_side_a r_dly_a [0:lcd_pkg::SQRT_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lcd_pkg::SQRT_STAGES; k++) begin
                r_dly_a[k] <= '0;
            end
        end else if (w_adv) begin
            r_dly_a[0] <= r_c_side;
            for (int k = 1; k < lcd_pkg::SQRT_STAGES; k++) begin
                r_dly_a[k] <= r_dly_a[k-1];
            end
        end
    end

    lcd_pkg::t_side_a w_side_a;
    logic [15:0]      w_c1, w_c2;
    assign w_side_a = r_dly_a[lcd_pkg::SQRT_STAGES-1];
    assign w_c1     = w_c1_root[15:0];
    assign w_c2     = w_c2_root[15:0];

    // Stage D: chroma difference and weight products.
    lcd_pkg::t_side_a r_d_side;
    logic [15:0]      r_d_dc;
    logic [27:0]      r_d_p1, r_d_p2;
    logic [11:0]      w_k1, w_k2;

    assign w_k1 = w_graphic ? lcd_pkg::K1_GRAPHIC : lcd_pkg::K1_TEXTILE;
    assign w_k2 = w_graphic ? lcd_pkg::K2_GRAPHIC : lcd_pkg::K2_TEXTILE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_side.valid <= 1'b0;
        end else if (w_adv) begin
            r_d_side <= w_side_a;
            r_d_dc   <= (w_c1 >= w_c2) ? (w_c1 - w_c2) : (w_c2 - w_c1);
            r_d_p1   <= 28'(w_k1) * 28'(w_c1);
            r_d_p2   <= 28'(w_k2) * 28'(w_c1);
        end
    end

    // Stage E: rounded weighting scales and the squared chroma difference.
    lcd_pkg::t_side_a               r_e_side;
    logic [15:0]                    r_e_dc;
    logic [31:0]                    r_e_dc2;
    logic [lcd_pkg::DIV_DEN_W-1:0]  r_e_sc, r_e_sh;
    logic [28:0]                    w_p1r, w_p2r;

    assign w_p1r = 29'(r_d_p1) + lcd_pkg::ROUND_HALF;
    assign w_p2r = 29'(r_d_p2) + lcd_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_side.valid <= 1'b0;
        end else if (w_adv) begin
            r_e_side <= r_d_side;
            r_e_dc   <= r_d_dc;
            r_e_dc2  <= 32'(r_d_dc) * 32'(r_d_dc);
            r_e_sc   <= lcd_pkg::SCALE_ONE + lcd_pkg::DIV_DEN_W'(w_p1r >> 16);
            r_e_sh   <= lcd_pkg::SCALE_ONE + lcd_pkg::DIV_DEN_W'(w_p2r >> 16);
        end
    end

    // Stage F: hue term squared with clamping, and the lightness term.
    logic [32:0]      r_f_dh2;
    lcd_pkg::t_side_b r_f_side;
    logic             w_neg;

    assign w_neg = (33'(r_e_dc2) > r_e_side.ab2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_side.valid <= 1'b0;
        end else if (w_adv) begin
            r_f_side.valid <= r_e_side.valid;
            r_f_side.flag  <= w_is94 && w_neg;
            r_f_side.tl    <= w_textile ? (r_e_side.dl2 >> 2) : r_e_side.dl2;
            r_f_side.sum76 <= r_e_side.sum76;
            r_f_side.dc    <= r_e_dc;
            r_f_side.sc    <= r_e_sc;
            r_f_side.sh    <= r_e_sh;
            r_f_dh2        <= w_neg ? 33'd0 : (r_e_side.ab2 - 33'(r_e_dc2));
        end
    end

    // Hue difference.
    logic [lcd_pkg::SQRT_OUT_W-1:0] w_h_root;

    lcd_sqrt u_sqrt_h (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_radicand (lcd_pkg::SQRT_IN_W'(r_f_dh2)),
        .o_root     (w_h_root)
    );

    lcd_pkg::t_side_b r_dly_b [0:lcd_pkg::SQRT_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lcd_pkg::SQRT_STAGES; k++) begin
                r_dly_b[k] <= '0;
            end
        end else if (w_adv) begin
            r_dly_b[0] <= r_f_side;
            for (int k = 1; k < lcd_pkg::SQRT_STAGES; k++) begin
                r_dly_b[k] <= r_dly_b[k-1];
            end
        end
    end

    lcd_pkg::t_side_b w_side_b;
    assign w_side_b = r_dly_b[lcd_pkg::SQRT_STAGES-1];

    // Chroma and hue quotients, both dividers running side by side.
    lcd_pkg::t_div w_div_c [0:lcd_pkg::DIV_STAGES-1];
    lcd_pkg::t_div w_div_h [0:lcd_pkg::DIV_STAGES-1];
    lcd_pkg::t_div r_div_c [1:lcd_pkg::DIV_STAGES];
    lcd_pkg::t_div r_div_h [1:lcd_pkg::DIV_STAGES];

    always_comb begin
        w_div_c[0] = lcd_pkg::div_init(
            lcd_pkg::DIV_NUM_W'({w_side_b.dc, lcd_pkg::FRAC_BITS'(0)}), w_side_b.sc);
        w_div_h[0] = lcd_pkg::div_init(
            lcd_pkg::DIV_NUM_W'({w_h_root[lcd_pkg::DIV_Q_W-1:0], lcd_pkg::FRAC_BITS'(0)}),
            w_side_b.sh);
        for (int k = 1; k < lcd_pkg::DIV_STAGES; k++) begin
            w_div_c[k] = r_div_c[k];
            w_div_h[k] = r_div_h[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < lcd_pkg::DIV_STAGES; k++) begin
                r_div_c[k+1] <= lcd_pkg::div_step(w_div_c[k]);
                r_div_h[k+1] <= lcd_pkg::div_step(w_div_h[k]);
            end
        end
    end

    lcd_pkg::t_side_c r_dly_c [0:lcd_pkg::DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lcd_pkg::DIV_STAGES; k++) begin
                r_dly_c[k] <= '0;
            end
        end else if (w_adv) begin
            r_dly_c[0].valid <= w_side_b.valid;
            r_dly_c[0].flag  <= w_side_b.flag;
            r_dly_c[0].tl    <= w_side_b.tl;
            r_dly_c[0].sum76 <= w_side_b.sum76;
            for (int k = 1; k < lcd_pkg::DIV_STAGES; k++) begin
                r_dly_c[k] <= r_dly_c[k-1];
            end
        end
    end

    lcd_pkg::t_side_c w_side_c;
    logic [lcd_pkg::DIV_Q_W-1:0] w_qc, w_qh;
    assign w_side_c = r_dly_c[lcd_pkg::DIV_STAGES-1];
    assign w_qc     = r_div_c[lcd_pkg::DIV_STAGES].quo;
    assign w_qh     = r_div_h[lcd_pkg::DIV_STAGES].quo;

    // Stage H: squared quotients.
    lcd_pkg::t_side_c r_h_side;
    logic [33:0]      r_h_qc2, r_h_qh2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_side.valid <= 1'b0;
        end else if (w_adv) begin
            r_h_side <= w_side_c;
            r_h_qc2  <= 34'(w_qc) * 34'(w_qc);
            r_h_qh2  <= 34'(w_qh) * 34'(w_qh);
        end
    end

    // Stage I: sum of the terms for the selected formula.
    lcd_pkg::t_side_d              r_i_side;
    logic [lcd_pkg::SQRT_IN_W-1:0] r_i_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_side.valid <= 1'b0;
        end else if (w_adv) begin
            r_i_side.valid <= r_h_side.valid;
            r_i_side.flag  <= r_h_side.flag;
            r_i_sum        <= w_is94
                ? (lcd_pkg::SQRT_IN_W'(r_h_side.tl) + lcd_pkg::SQRT_IN_W'(r_h_qc2)
                   + lcd_pkg::SQRT_IN_W'(r_h_qh2))
                : lcd_pkg::SQRT_IN_W'(r_h_side.sum76);
        end
    end

    // Final square root.
    logic [lcd_pkg::SQRT_OUT_W-1:0] w_e_root;

    lcd_sqrt u_sqrt_e (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_radicand (r_i_sum),
        .o_root     (w_e_root)
    );

    lcd_pkg::t_side_d r_dly_d [0:lcd_pkg::SQRT_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lcd_pkg::SQRT_STAGES; k++) begin
                r_dly_d[k] <= '0;
            end
        end else if (w_adv) begin
            r_dly_d[0] <= r_i_side;
            for (int k = 1; k < lcd_pkg::SQRT_STAGES; k++) begin
                r_dly_d[k] <= r_dly_d[k-1];
            end
        end
    end

    // Output register with saturation. It holds while a valid result is stalled by the receiver.
    logic        r_o_vld;
    logic [16:0] r_o_diff;
    logic        r_o_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld  <= r_dly_d[lcd_pkg::SQRT_STAGES-1].valid;
            r_o_flag <= r_dly_d[lcd_pkg::SQRT_STAGES-1].flag;
            r_o_diff <= w_e_root[lcd_pkg::SQRT_OUT_W-1] ? lcd_pkg::DIFF_MAX : w_e_root[16:0];
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_difference  = r_o_diff;
    assign o_hue_clamped = r_o_flag;

endmodule
